@@ src/sorted_array_priority_queue_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion shorthands for the sorted array priority queue.
// ----------------------------------------------------------------------------
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define SAPQ_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SAPQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/sapq_pkg.sv @@
// ----------------------------------------------------------------------------
// sapq_pkg
// Types and constants shared by the sorted array priority queue modules.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int VALUE_W       = 32;
    localparam int CAP_W         = 4;
    localparam int OCC_W         = 4;
    localparam int ACTION_W      = 2;
    localparam int STATUS_W      = 2;
    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_PEEK    = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RESP = 1'b1
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;      // capture a result this cycle
        logic    insert;    // sorted insert of the incoming value
        logic    remove;    // drop the head entry
        logic    show_head; // result carries the head entry
        status_t code;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
    } stat_t;

endpackage

@@ src/sapq_ctrl.sv @@
// ----------------------------------------------------------------------------
// sapq_ctrl
// Handshake controller: decodes each item and holds its result until taken.
// ----------------------------------------------------------------------------
module sapq_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [sapq_pkg::ACTION_W-1:0]  s_action,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  sapq_pkg::stat_t                stat,
    output sapq_pkg::cmd_t                 cmd
);
    import sapq_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        cmd.load      = 1'b0;
        cmd.insert    = 1'b0;
        cmd.remove    = 1'b0;
        cmd.show_head = 1'b0;
        cmd.code      = ST_OK;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_RESP;
                    unique case (action_t'(s_action)) inside
                        ACT_ENQUEUE: begin
                            if (stat.full) begin
                                cmd.code = ST_FULL;
                            end else begin
                                cmd.insert = 1'b1;
                            end
                        end
                        ACT_DEQUEUE, ACT_PEEK: begin
                            if (stat.empty) begin
                                cmd.code = ST_EMPTY;
                            end else begin
                                cmd.show_head = 1'b1;
                                cmd.remove    = (action_t'(s_action) == ACT_DEQUEUE);
                            end
                        end
                        default: begin
                            cmd.code = ST_OK;
                        end
                    endcase
                end
            end
            S_RESP: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/sapq_datapath.sv @@
// ----------------------------------------------------------------------------
// sapq_datapath
// Row of sorted cells, entry count, capacity register and result registers.
// ----------------------------------------------------------------------------
`include "sorted_array_priority_queue_assert.svh"

module sapq_datapath #(
    parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic        [sapq_pkg::CAP_W-1:0]   cfg_data,
    input  logic signed [sapq_pkg::VALUE_W-1:0] in_value,
    input  sapq_pkg::cmd_t                      cmd,
    output sapq_pkg::stat_t                     stat,
    output logic        [sapq_pkg::STATUS_W-1:0] out_status,
    output logic signed [sapq_pkg::VALUE_W-1:0] out_value,
    output logic        [sapq_pkg::OCC_W-1:0]   out_occupancy
);
    import sapq_pkg::*;

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int EXTW = (CMPW > OCC_W) ? CMPW : OCC_W;

    logic signed [VALUE_W-1:0] entries_reg  [DEPTH];
    logic signed [VALUE_W-1:0] entries_next [DEPTH];
    logic        [DEPTH-1:0]   keep;
    logic        [CW-1:0]      count_reg;
    logic        [CW-1:0]      count_next;
    logic        [CAP_W-1:0]   cap_reg;
    logic        [CMPW-1:0]    count_cmp;
    logic        [EXTW-1:0]    occ_ext;
    logic        [STATUS_W-1:0] status_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic        [OCC_W-1:0]   occ_reg;

    assign count_cmp  = CMPW'(count_reg);
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_cmp >= CMPW'(DEPTH)) || (count_cmp >= CMPW'(cap_reg));

    // Entries at or below the new value stay put; they form a prefix of the row.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            keep[i] = (CW'(i) < count_reg) && (entries_reg[i] <= in_value);
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entries_next[i] = entries_reg[i];
            if (cmd.insert) begin
                if (!keep[i]) begin
                    if (i == 0) begin
                        entries_next[i] = in_value;
                    end else if (keep[i-1]) begin
                        entries_next[i] = in_value;
                    end else begin
                        entries_next[i] = entries_reg[i-1];
                    end
                end
            end else if (cmd.remove && (i < DEPTH - 1)) begin
                entries_next[i] = entries_reg[i+1];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.insert) begin
            count_next = count_reg + CW'(1);
        end else if (cmd.remove) begin
            count_next = count_reg - CW'(1);
        end
    end

    assign occ_ext = EXTW'(count_next);

    always_ff @(posedge aclk) begin
        for (int i = 0; i < DEPTH; i++) begin
            entries_reg[i] <= entries_next[i];
        end
        if (cmd.load) begin
            status_reg <= cmd.code;
            value_reg  <= cmd.show_head ? entries_reg[0] : '0;
            occ_reg    <= occ_ext[OCC_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
        end else begin
            count_reg <= count_next;
            if (cfg_we) begin
                cap_reg <= cfg_data;
            end
        end
    end

    assign out_status    = status_reg;
    assign out_value     = value_reg;
    assign out_occupancy = occ_reg;

    `SAPQ_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_cmp <= CMPW'(DEPTH), "count above depth")
    `SAPQ_ASSERT_NOW(a_one_update, aclk, aresetn, cmd.insert || cmd.remove, cmd.load && !(cmd.insert && cmd.remove), "conflicting update")
    `SAPQ_ASSERT_NEXT(a_insert_count, aclk, aresetn, cmd.insert, count_reg == $past(count_reg) + CW'(1), "insert count")
    `SAPQ_ASSERT_NEXT(a_remove_count, aclk, aresetn, cmd.remove, count_reg == $past(count_reg) - CW'(1), "remove count")
    `SAPQ_ASSERT_NOW(a_head_sorted, aclk, aresetn, count_reg >= CW'(2), entries_reg[0] <= entries_reg[1], "head out of order")

endmodule

@@ src/sorted_array_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Bounded min-priority queue held as an ascending row of cells.
// ----------------------------------------------------------------------------
// Each item is one operation (tuser: 0 enqueue, 1 dequeue, 2 peek, 3 no-op)
// and gives exactly one result. Enqueue places the value after all equal
// entries, so ties leave in arrival order; every cell compares against the
// new value at once, so an insert or a removal completes in the accept cycle.
// The result is valid the cycle after the item is accepted and is held until
// taken; the controller alternates between accepting and presenting, so the
// block takes no new item until the result of the last one has been taken.
// Capacity (reset 8, values above DEPTH act as DEPTH) must be written by the user
// through the cfg channel while no item is in flight; the block does not enforce this.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue #(
    parameter int DEPTH = sapq_pkg::DEPTH_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // capacity register
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sapq_pkg::CAP_W-1:0]       cfg_data,
    // operation items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [31:0] value
    input  logic [sapq_pkg::ACTION_W-1:0]    s_tuser,   // [1:0] action
    // result items
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [39:0]                      m_tdata,   // [31:0] result_value, [35:32] occupancy
    output logic [sapq_pkg::STATUS_W-1:0]    m_tuser    // [1:0] status
);
    import sapq_pkg::*;

    cmd_t  cmd;
    stat_t stat;
    logic signed [VALUE_W-1:0] res_value;
    logic        [OCC_W-1:0]   res_occ;

    assign cfg_ready = 1'b1;

    sapq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    sapq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_valid),
        .cfg_data      (cfg_data),
        .in_value      (s_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .out_status    (m_tuser),
        .out_value     (res_value),
        .out_occupancy (res_occ)
    );

    assign m_tdata = {4'b0000, res_occ, res_value};

endmodule
